// ===== src/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ARR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define ARR_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

// Check that a condition holds in the same cycle as a trigger.
`define ARR_ASSERT_SAME(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

`endif

// ===== src/arr_pkg.sv =====
// Shared types and constants of the audio rate resampler.
// No dependencies; imported by every module of the block.
package arr_pkg;

	localparam int SMP_W     = 16;
	localparam int IDX_W     = 24;
	localparam int STEP_W    = 24;
	localparam int HALF_W    = 4;
	localparam int MU_W      = 24;
	localparam int POS_W     = 48;
	localparam int CFG_IDX_W = 3;

	localparam logic [IDX_W-1:0] IDX_MAX = '1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_STEP      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IN_16BIT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_8BIT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_HALF  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_COUNT = 3'd4;

	// Live settings used by the back end
	typedef struct packed {
		logic             out_is_8bit;
		logic [IDX_W-1:0] out_count;
	} cfg_t;

	// One classified source word, front to back
	typedef struct packed {
		logic [SMP_W-1:0]  smp;
		logic [SMP_W-1:0]  prev;
		logic [IDX_W-1:0]  k;
		logic              last;
		logic              up;
		logic [STEP_W-1:0] step;
		logic [HALF_W-1:0] half;
	} job_t;

	typedef enum logic [1:0] {
		OP_EMIT  = 2'd0,
		OP_FLUSH = 2'd1,
		OP_MARK  = 2'd2
	} op_kind_t;

	// One datapath operation issued by the sequencer
	typedef struct packed {
		op_kind_t          kind;
		logic [SMP_W-1:0]  a;
		logic [SMP_W-1:0]  b;
		logic [MU_W-1:0]   mu;
		logic              init;
		logic              avg;
		logic [HALF_W-1:0] half;
		logic              fin;
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_LOOP_A = 5'b00010,
		ST_LOOP_B = 5'b00100,
		ST_FLUSH  = 5'b01000,
		ST_DONE   = 5'b10000
	} seq_state_t;

endpackage

// ===== src/arr_fifo.sv =====
// Two-entry job queue between the front end and the sequencer.
// Depends on arr_pkg for job_t.
module arr_fifo
	import arr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t din,
	input  logic pop,
	output job_t dout,
	output logic full,
	output logic empty
);

	job_t       mem_q [0:1];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign dout  = mem_q[rd_q];
	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);

	// Store a pushed word
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ===== src/arr_front.sv =====
// Front end: configuration registers, sample conversion and per-sound latching.
// Depends on arr_pkg; feeds classified words into the job queue.
module arr_front
	import arr_pkg::*;
#(
	parameter int FRAC_BITS      = 16,
	parameter int MAX_HALF_WIDTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [SMP_W-1:0]     in_sample,
	input  logic                 in_last,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [STEP_W-1:0]    cfg_data,
	input  logic                 q_full,
	output logic                 q_push,
	output job_t                 job,
	output cfg_t                 cfg
);

	localparam logic [STEP_W:0]   ONE_POS  = (STEP_W+1)'(1) << FRAC_BITS;
	localparam logic [STEP_W-1:0] MIN_STEP = STEP_W'(ONE_POS >> 4);

	logic [STEP_W-1:0] step_q;
	logic              in16_q;
	logic              out8_q;
	logic [2:0]        box_q;
	logic [IDX_W-1:0]  count_q;

	logic [IDX_W-1:0]  k_q;
	logic [SMP_W-1:0]  prev_q;
	logic [STEP_W-1:0] lstep_q;
	logic [HALF_W-1:0] lhalf_q;

	logic              accept;
	logic [SMP_W-1:0]  smp_c;
	logic [STEP_W-1:0] step_new;
	logic              up_new;
	logic [HALF_W-1:0] half_new;
	logic              first;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_full;
	assign accept    = in_valid && !q_full;
	assign q_push    = accept;
	assign first     = (k_q == '0);

	assign cfg.out_is_8bit = out8_q;
	assign cfg.out_count   = count_q;

	// Scale the raw word to signed 16 bits
	assign smp_c = in16_q ? in_sample : {in_sample[7:0] ^ 8'h80, 8'h00};

	// Clamp step and half width for a new sound
	always_comb begin
		step_new = (step_q < MIN_STEP) ? MIN_STEP : step_q;
		up_new   = ({1'b0, step_new} < ONE_POS);
		if (!up_new) begin
			half_new = '0;
		end else if ({1'b0, box_q} > HALF_W'(MAX_HALF_WIDTH)) begin
			half_new = HALF_W'(MAX_HALF_WIDTH);
		end else begin
			half_new = {1'b0, box_q};
		end
	end

	always_comb begin
		job.smp  = smp_c;
		job.prev = prev_q;
		job.k    = k_q;
		job.last = in_last;
		job.step = first ? step_new : lstep_q;
		job.half = first ? half_new : lhalf_q;
		job.up   = ({1'b0, job.step} < ONE_POS);
	end

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= 24'h010000;
			in16_q  <= 1'b1;
			out8_q  <= 1'b0;
			box_q   <= 3'd0;
			count_q <= 24'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_STEP:      step_q  <= cfg_data;
				CFG_IN_16BIT:  in16_q  <= cfg_data[0];
				CFG_OUT_8BIT:  out8_q  <= cfg_data[0];
				CFG_BOX_HALF:  box_q   <= cfg_data[2:0];
				CFG_OUT_COUNT: count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Track source index and previous word; latch step and width per sound
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q     <= '0;
			prev_q  <= '0;
			lstep_q <= STEP_W'(ONE_POS);
			lhalf_q <= '0;
		end else if (accept) begin
			if (first) begin
				lstep_q <= step_new;
				lhalf_q <= half_new;
			end
			if (in_last) begin
				k_q    <= '0;
				prev_q <= '0;
			end else begin
				prev_q <= smp_c;
				if (k_q != IDX_MAX) begin
					k_q <= k_q + IDX_W'(1);
				end
			end
		end
	end

endmodule

// ===== src/arr_seq.sv =====
// Back-end sequencer: walks output positions for each queued word.
// Depends on arr_pkg; issues one datapath operation per cycle at most.
module arr_seq
	import arr_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             q_empty,
	output logic             q_pop,
	input  job_t             job,
	input  logic [IDX_W-1:0] out_count,
	output logic             op_valid,
	output op_t              op
);

	localparam int PI_W = POS_W - FRAC_BITS;

	seq_state_t        state_q;
	job_t              job_q;
	logic [POS_W-1:0]  pos_q;
	logic [IDX_W-1:0]  oidx_q;
	logic              fin_q;
	logic              finj_q;
	logic [HALF_W-1:0] fk_q;
	logic              op_valid_q;
	op_t               op_q;

	logic [PI_W-1:0]  pos_int;
	logic             hit_a;
	logic             hit_b;
	logic [IDX_W-1:0] oidx_inc;
	logic             reach;
	logic             flush_skip;
	logic             fl_avg;
	logic             fl_end;
	logic [POS_W-1:0] pos_inc;

	assign op_valid = op_valid_q;
	assign op       = op_q;
	assign q_pop    = adv && (state_q == ST_IDLE) && !q_empty;

	assign pos_int    = pos_q[POS_W-1:FRAC_BITS];
	assign hit_a      = !fin_q && (pos_int == PI_W'(job_q.k - IDX_W'(1)));
	assign hit_b      = !fin_q && (pos_int == PI_W'(job_q.k));
	assign oidx_inc   = oidx_q + IDX_W'(1);
	assign reach      = (oidx_inc >= out_count);
	assign pos_inc    = pos_q + POS_W'(job_q.step);
	assign flush_skip = (job_q.half == '0) || (oidx_q == '0);
	assign fl_avg     = (({1'b0, oidx_q} + (IDX_W+1)'(fk_q)) >= (IDX_W+1)'(job_q.half));
	assign fl_end     = (fk_q == job_q.half - HALF_W'(1));

	// Step through the output loops of the current word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pos_q      <= '0;
			oidx_q     <= '0;
			fin_q      <= 1'b0;
			finj_q     <= 1'b0;
			fk_q       <= '0;
			op_valid_q <= 1'b0;
		end else if (adv) begin
			op_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						job_q  <= job;
						finj_q <= 1'b0;
						if (job.up && (job.k != '0)) begin
							state_q <= ST_LOOP_A;
						end else if (!job.up || job.last) begin
							state_q <= ST_LOOP_B;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_LOOP_A: begin
					if (hit_a) begin
						op_valid_q <= 1'b1;
						op_q.kind  <= OP_EMIT;
						op_q.a     <= job_q.prev;
						op_q.b     <= job_q.smp;
						op_q.mu    <= MU_W'(pos_q[FRAC_BITS-1:0]);
						op_q.init  <= (oidx_q == '0);
						op_q.avg   <= (oidx_q >= IDX_W'(job_q.half));
						op_q.half  <= job_q.half;
						op_q.fin   <= 1'b0;
						pos_q      <= pos_inc;
						oidx_q     <= oidx_inc;
						if (reach) begin
							fk_q    <= '0;
							state_q <= ST_FLUSH;
						end
					end else begin
						state_q <= job_q.last ? ST_LOOP_B : ST_DONE;
					end
				end
				ST_LOOP_B: begin
					if (hit_b) begin
						op_valid_q <= 1'b1;
						op_q.kind  <= OP_EMIT;
						op_q.a     <= job_q.smp;
						op_q.b     <= job_q.smp;
						op_q.mu    <= '0;
						op_q.init  <= (oidx_q == '0);
						op_q.avg   <= (oidx_q >= IDX_W'(job_q.half));
						op_q.half  <= job_q.half;
						op_q.fin   <= 1'b0;
						pos_q      <= pos_inc;
						oidx_q     <= oidx_inc;
						if (reach) begin
							fk_q    <= '0;
							state_q <= ST_FLUSH;
						end
					end else begin
						fk_q    <= '0;
						state_q <= (job_q.last && !fin_q) ? ST_FLUSH : ST_DONE;
					end
				end
				ST_FLUSH: begin
					if (flush_skip) begin
						fin_q   <= 1'b1;
						finj_q  <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						op_valid_q <= 1'b1;
						op_q.kind  <= OP_FLUSH;
						op_q.a     <= '0;
						op_q.b     <= '0;
						op_q.mu    <= '0;
						op_q.init  <= 1'b0;
						op_q.avg   <= fl_avg;
						op_q.half  <= job_q.half;
						op_q.fin   <= 1'b0;
						fk_q       <= fk_q + HALF_W'(1);
						if (fl_end) begin
							fin_q   <= 1'b1;
							finj_q  <= 1'b1;
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					op_valid_q <= 1'b1;
					op_q.kind  <= OP_MARK;
					op_q.a     <= '0;
					op_q.b     <= '0;
					op_q.mu    <= '0;
					op_q.init  <= 1'b0;
					op_q.avg   <= 1'b0;
					op_q.half  <= job_q.half;
					op_q.fin   <= finj_q;
					if (job_q.last) begin
						pos_q  <= '0;
						oidx_q <= '0;
						fin_q  <= 1'b0;
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== src/arr_dpath.sv =====
// Back-end datapath: interpolation, moving average, word hold and output register.
// Depends on arr_pkg; consumes operations from arr_seq.
module arr_dpath
	import arr_pkg::*;
#(
	parameter int FRAC_BITS      = 16,
	parameter int MAX_HALF_WIDTH = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    op_valid,
	input  op_t                     op,
	input  logic                    out8,
	input  logic                    out_stall,
	output logic                    adv,
	output logic                    out_valid,
	output logic signed [SMP_W-1:0] out_sample,
	output logic                    run_last,
	output logic                    sound_done
);

	localparam int PROD_W = SMP_W + 2 + FRAC_BITS;
	localparam int WIN_D  = 2 * MAX_HALF_WIDTH + 1;
	localparam int L_W    = $clog2(WIN_D);
	localparam int WIDX_W = $clog2(WIN_D);
	localparam int HIDX_W = $clog2(MAX_HALF_WIDTH + 1);
	localparam int SUM_W  = SMP_W + L_W;
	localparam int SH     = SUM_W + L_W;
	localparam int P5_W   = SUM_W + SH + 1;

	// Reciprocals of the window lengths, exact for all sums in range
	logic [SH:0] recip [0:MAX_HALF_WIDTH];
	for (genvar g = 0; g <= MAX_HALF_WIDTH; g++) begin : g_recip
		localparam longint unsigned RV = ((64'd1 << SH) / (2 * g + 1)) + 1;
		assign recip[g] = (SH+1)'(RV);
	end

	logic                     vld_s2;
	op_t                      op_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic                     vld_s3;
	op_t                      op_s3;
	logic [SMP_W-1:0]         val_s3;
	logic                     res_s4;
	logic                     mark_s4;
	logic                     fin_s4;
	logic signed [SUM_W-1:0]  sum_s4;
	logic [HALF_W-1:0]        half_s4;
	logic                     res_s5;
	logic                     mark_s5;
	logic                     fin_s5;
	logic                     neg_s5;
	logic [P5_W-1:0]          prod_s5;

	logic [SMP_W-1:0]        win_q [0:WIN_D-1];
	logic [SMP_W-1:0]        win_n [0:WIN_D-1];
	logic signed [SUM_W-1:0] wsum_q;

	logic                     hold_v_q;
	logic [SMP_W-1:0]         hold_q;
	logic                     out_valid_q;
	logic [SMP_W-1:0]         out_sample_q;
	logic                     run_last_q;
	logic                     sound_done_q;

	logic signed [SMP_W:0]    diff_c;
	logic signed [MU_W:0]     mu_c;
	logic signed [PROD_W-1:0] prod_c;
	logic signed [PROD_W-1:0] num_c;
	logic signed [PROD_W-1:0] num_adj;
	logic [WIDX_W-1:0]        w_idx;
	logic [SMP_W-1:0]         u_c;
	logic signed [SUM_W-1:0]  u_ext;
	logic signed [SUM_W-1:0]  w0_ext;
	logic signed [SUM_W-1:0]  dcnt;
	logic signed [SUM_W-1:0]  sum_new;
	logic                     win_upd;
	logic [SUM_W-1:0]         mag_c;
	logic [SMP_W:0]           q_c;
	logic [SMP_W:0]           sq_c;
	logic [SMP_W-1:0]         res_val;

	assign adv        = !out_valid_q || !out_stall;
	assign out_valid  = out_valid_q;
	assign out_sample = out_sample_q;
	assign run_last   = run_last_q;
	assign sound_done = sound_done_q;

	// Stage 2: slope times fraction
	assign diff_c = $signed({op.b[SMP_W-1], op.b}) - $signed({op.a[SMP_W-1], op.a});
	assign mu_c   = $signed({1'b0, MU_W'(op.mu[FRAC_BITS-1:0])});
	assign prod_c = diff_c * mu_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= op_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s2   <= op;
			prod_s2 <= prod_c;
		end
	end

	// Stage 3: add base and truncate toward zero
	assign num_c   = $signed({{(PROD_W-SMP_W-FRAC_BITS){op_s2.a[SMP_W-1]}}, op_s2.a,
		{FRAC_BITS{1'b0}}}) + prod_s2;
	assign num_adj = num_c + (num_c[PROD_W-1]
		? $signed({{(PROD_W-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}}) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s3  <= op_s2;
			val_s3 <= num_adj[FRAC_BITS +: SMP_W];
		end
	end

	// Stage 4: moving-average window
	assign w_idx   = WIDX_W'({op_s3.half, 1'b0});
	assign u_c     = (op_s3.kind == OP_FLUSH) ? win_q[w_idx]
		: (out8 ? {val_s3[SMP_W-1:8], 8'h00} : val_s3);
	assign u_ext   = $signed({{(SUM_W-SMP_W){u_c[SMP_W-1]}}, u_c});
	assign w0_ext  = $signed({{(SUM_W-SMP_W){win_q[0][SMP_W-1]}}, win_q[0]});
	assign dcnt    = $signed(SUM_W'({op_s3.half, 1'b1}));
	assign win_upd = vld_s3 && (op_s3.kind != OP_MARK);

	always_comb begin
		if ((op_s3.kind == OP_EMIT) && op_s3.init) begin
			sum_new = u_ext * dcnt;
		end else begin
			sum_new = wsum_q + u_ext - w0_ext;
		end
		for (int i = 0; i < WIN_D; i++) begin
			win_n[i] = win_q[i];
			if ((op_s3.kind == OP_EMIT) && op_s3.init) begin
				win_n[i] = u_c;
			end else if (WIDX_W'(i) == w_idx) begin
				win_n[i] = u_c;
			end else if (WIDX_W'(i) < w_idx) begin
				win_n[i] = win_q[(i + 1) % WIN_D];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && win_upd) begin
			win_q  <= win_n;
			wsum_q <= sum_new;
		end
		if (adv) begin
			sum_s4  <= sum_new;
			half_s4 <= op_s3.half;
			fin_s4  <= op_s3.fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s4  <= 1'b0;
			mark_s4 <= 1'b0;
		end else if (adv) begin
			res_s4  <= win_upd && op_s3.avg;
			mark_s4 <= vld_s3 && (op_s3.kind == OP_MARK);
		end
	end

	// Stage 5: divide by window length through its reciprocal
	assign mag_c = sum_s4[SUM_W-1] ? SUM_W'(-sum_s4) : SUM_W'(sum_s4);

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s5  <= sum_s4[SUM_W-1];
			fin_s5  <= fin_s4;
			prod_s5 <= P5_W'(mag_c) * P5_W'(recip[half_s4[HIDX_W-1:0]]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s5  <= 1'b0;
			mark_s5 <= 1'b0;
		end else if (adv) begin
			res_s5  <= res_s4;
			mark_s5 <= mark_s4;
		end
	end

	// Restore sign and quantize
	assign q_c     = prod_s5[SH +: SMP_W+1];
	assign sq_c    = neg_s5 ? (SMP_W+1)'(-q_c) : q_c;
	assign res_val = out8 ? {{8{sq_c[SMP_W-1]}}, sq_c[SMP_W-1:8]} : sq_c[SMP_W-1:0];

	// Hold one word until the next one or the end mark shows its flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q     <= 1'b0;
			hold_q       <= '0;
			out_valid_q  <= 1'b0;
			out_sample_q <= '0;
			run_last_q   <= 1'b0;
			sound_done_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b0;
			if (res_s5) begin
				if (hold_v_q) begin
					out_valid_q  <= 1'b1;
					out_sample_q <= hold_q;
					run_last_q   <= 1'b0;
					sound_done_q <= 1'b0;
				end
				hold_q   <= res_val;
				hold_v_q <= 1'b1;
			end else if (mark_s5 && hold_v_q) begin
				out_valid_q  <= 1'b1;
				out_sample_q <= hold_q;
				run_last_q   <= 1'b1;
				sound_done_q <= fin_s5;
				hold_v_q     <= 1'b0;
			end
		end
	end

endmodule

// ===== src/audio_rate_resampler_top.sv =====
// Audio rate resampler: linear interpolation / decimation with moving average.
// Source words enter on the in channel (valid/stall); each accepted word yields
// zero or more output words on the out channel (valid/stall). The last output
// word of an input carries run_last; the final word of a sound carries
// sound_done. Settings are written on the cfg channel (valid/ready, always
// ready); the user must write them only while the block is idle, and the block
// does not enforce this. Step and half width are taken at the first word of each sound.
// The sequencer takes a queued word, walks its output positions, issuing one per
// cycle while the output is not stalled, then flushes the averaging tail if the
// word ends a sound and closes the word with an end mark. A two-entry queue
// decouples the input from the sequencer.
// An output word passes datapath stages 2 to 5 and the word hold, and leaves once
// the next word of the same input or the end of that input's run is known.
// Reset clears all sound state and restores register defaults. A stalled
// output freezes the whole back end; input stalls once the queue is full.
module audio_rate_resampler_top
	import arr_pkg::*;
#(
	parameter int FRAC_BITS      = 16,
	parameter int MAX_HALF_WIDTH = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [SMP_W-1:0]        in_sample,
	input  logic                    in_last,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [SMP_W-1:0] out_sample,
	output logic                    run_last,
	output logic                    sound_done,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [STEP_W-1:0]       cfg_data
);

	job_t job_in;
	job_t job_out;
	cfg_t cfg;
	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_empty;
	logic adv;
	logic op_valid;
	op_t  op;

	arr_front #(
		.FRAC_BITS     (FRAC_BITS),
		.MAX_HALF_WIDTH(MAX_HALF_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_sample(in_sample),
		.in_last  (in_last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.q_full   (q_full),
		.q_push   (q_push),
		.job      (job_in),
		.cfg      (cfg)
	);

	arr_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.din   (job_in),
		.pop   (q_pop),
		.dout  (job_out),
		.full  (q_full),
		.empty (q_empty)
	);

	arr_seq #(
		.FRAC_BITS(FRAC_BITS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.job      (job_out),
		.out_count(cfg.out_count),
		.op_valid (op_valid),
		.op       (op)
	);

	arr_dpath #(
		.FRAC_BITS     (FRAC_BITS),
		.MAX_HALF_WIDTH(MAX_HALF_WIDTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op        (op),
		.out8      (cfg.out_is_8bit),
		.out_stall (out_stall),
		.adv       (adv),
		.out_valid (out_valid),
		.out_sample(out_sample),
		.run_last  (run_last),
		.sound_done(sound_done)
	);

endmodule

// ===== src/arr_chk.sv =====
// Port-level checker for the audio rate resampler, bound to the top level.
// Depends on assert_macros.svh and arr_pkg.
`include "assert_macros.svh"

module arr_chk
	import arr_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic [SMP_W-1:0]     in_sample,
	input logic                 in_last,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [SMP_W-1:0]     out_sample,
	input logic                 run_last,
	input logic                 sound_done,
	input logic                 cfg_valid,
	input logic                 cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [STEP_W-1:0]    cfg_data
);

	// Hold a stalled output word
	`ARR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_sample) && $stable(run_last) && $stable(sound_done), "stalled output word changed")

	// End of sound always closes the run of its input
	`ARR_ASSERT_SAME(a_done_last, out_valid && sound_done, run_last, "sound_done without run_last")

	// Configuration port never backs up
	`ARR_ASSERT(a_cfg_ready, cfg_ready, "configuration port not ready")

	// After a taken run_last word, sound_done is checked to come only with run_last
	`ARR_ASSERT_NEXT(a_flag_clear, out_valid && !out_stall && run_last, !out_valid || !sound_done || run_last, "sound_done on non-final word")

endmodule

bind audio_rate_resampler_top arr_chk u_chk (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for audio_rate_resampler_top: directed table, then random sounds.
// Depends on arr_pkg and the RTL; carries its own resampling and averaging predictor.
`timescale 1ns / 100ps

module testbench;
	import arr_pkg::*;

	typedef struct {
		logic [SMP_W-1:0] smp;
		logic             run_last;
		logic             sound_done;
	} out_word_t;

	typedef enum {ROW_WORD, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t           kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [STEP_W-1:0]   data;
		logic                last;
		int                  n_typed;
		logic [SMP_W-1:0]    typed_smp;
	} stim_row_t;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	logic [SMP_W-1:0]        in_sample;
	logic                    in_last;
	logic                    out_valid;
	logic                    out_stall;
	logic signed [SMP_W-1:0] out_sample;
	logic                    run_last;
	logic                    sound_done;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [STEP_W-1:0]       cfg_data;

	// Register copies and sound state of the predictor
	int unsigned    r_step, r_in16, r_out8, r_half, r_count;
	bit [63:0]      pos;
	int             prev_smp;
	int unsigned    src_idx, out_idx, filt_idx;
	int             win [9];
	int             win_sum;
	bit [63:0]      snd_step;
	int unsigned    snd_half;
	bit             snd_over;

	out_word_t      expected_q [$];
	out_word_t      word_res [$];
	int             errors;
	int             burst_left;
	bit             hold_req;

	audio_rate_resampler_top i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic int top_byte(int v);
		return ((v + 32768) >>> 8) - 128;
	endfunction

	function automatic void clear_sound();
		pos = 0;
		prev_smp = 0;
		src_idx = 0;
		out_idx = 0;
		filt_idx = 0;
		foreach (win[i]) win[i] = 0;
		win_sum = 0;
		snd_step = 64'h10000;
		snd_half = 0;
		snd_over = 1'b0;
	endfunction

	function automatic void add_res(int v);
		out_word_t w;
		w.smp = v[15:0];
		w.run_last = 1'b0;
		w.sound_done = 1'b0;
		word_res.push_back(w);
	endfunction

	// Shift the averaging window by one value
	function automatic void win_shift(int u);
		int w;
		w = 2 * snd_half;
		win_sum += u - win[0];
		for (int i = 0; i < w; i++) win[i] = win[i+1];
		win[w] = u;
	endfunction

	function automatic void add_average();
		int a;
		a = win_sum / int'(2 * snd_half + 1);
		add_res(r_out8 ? top_byte(a) : a);
		filt_idx = (filt_idx + 1) & 24'hFFFFFF;
	endfunction

	// Flush the averaging tail and close the sound
	function automatic void close_sound();
		int lst, tail, center;
		if (snd_half > 0 && out_idx > 0) begin
			lst = int'(out_idx) - 1;
			tail = win[2*snd_half];
			for (int k = 0; k < snd_half; k++) begin
				center = lst - int'(snd_half) + 1 + k;
				win_shift(tail);
				if (center >= 0) add_average();
			end
		end
		snd_over = 1'b1;
		if (word_res.size() > 0) word_res[$].sound_done = 1'b1;
	endfunction

	function automatic void make_output(int v);
		int u;
		if (snd_half == 0) begin
			add_res(r_out8 ? top_byte(v) : v);
		end else begin
			u = r_out8 ? top_byte(v) * 256 : v;
			if (out_idx == 0) begin
				for (int k = 0; k < 2 * snd_half + 1; k++) win[k] = u;
				win_sum = u * int'(2 * snd_half + 1);
			end else begin
				win_shift(u);
			end
			if (out_idx >= snd_half) add_average();
		end
		pos += snd_step;
		out_idx = (out_idx + 1) & 24'hFFFFFF;
		if (out_idx >= r_count) close_sound();
	endfunction

	function automatic int lerp(int a, int b);
		longint mu, num;
		mu = longint'(pos & 64'hFFFF);
		num = longint'(a) * (65536 - mu) + longint'(b) * mu;
		return int'(num / 65536);
	endfunction

	// Work out the output words caused by one source word
	function automatic void resample_word(logic [SMP_W-1:0] raw, logic lst);
		int s;
		int unsigned k;
		k = src_idx;
		word_res.delete();
		if (r_in16) s = int'($signed(raw));
		else s = (int'(raw[7:0]) - 128) * 256;
		if (!snd_over) begin
			if (k == 0) begin
				snd_step = (r_step < 4096) ? 64'd4096 : 64'(r_step);
				snd_half = (snd_step < 64'h10000) ? ((r_half > 4) ? 4 : r_half) : 0;
			end
			if (snd_step < 64'h10000) begin
				if (k > 0)
					while (!snd_over && (pos >> 16) == 64'(k - 1)) make_output(lerp(prev_smp, s));
				if (lst)
					while (!snd_over && (pos >> 16) == 64'(k)) make_output(s);
			end else begin
				while (!snd_over && (pos >> 16) == 64'(k)) make_output(s);
			end
			if (lst && !snd_over) close_sound();
		end
		if (lst) begin
			clear_sound();
		end else begin
			prev_smp = s;
			if (src_idx < 24'hFFFFFF) src_idx++;
		end
		if (word_res.size() > 0) word_res[$].run_last = 1'b1;
	endfunction

	// Offer one source word and hold it until taken
	task automatic send_word(logic [SMP_W-1:0] smp, logic lst, int n_typed,
		logic [SMP_W-1:0] typed_smp);
		out_word_t w;
		in_sample <= smp;
		in_last <= lst;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		resample_word(smp, lst);
		if (n_typed >= 0) begin
			word_res.delete();
			if (n_typed > 0) begin
				w.smp = typed_smp;
				w.run_last = 1'b1;
				w.sound_done = 1'b1;
				word_res.push_back(w);
			end
		end
		foreach (word_res[i]) expected_q.push_back(word_res[i]);
		// Continue the burst or drop valid for a random gap
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			int gap;
			gap = $urandom_range(0, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(0, 12);
		end
	endtask

	// Wait until every expected word is out and the block has settled
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() > 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [STEP_W-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_STEP:      r_step = 32'(data);
			CFG_IN_16BIT:  r_in16 = 32'(data[0]);
			CFG_OUT_8BIT:  r_out8 = 32'(data[0]);
			CFG_BOX_HALF:  r_half = 32'(data[2:0]);
			CFG_OUT_COUNT: r_count = 32'(data);
			default: ;
		endcase
	endtask

	// Compare each accepted output word with the oldest expectation
	always @(posedge clk) begin
		out_word_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected word sample=%h run_last=%b sound_done=%b",
					$realtime, out_sample, run_last, sound_done);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (out_sample !== e.smp) begin
					$display("%0t: out_sample expected %h actual %h", $realtime, e.smp, out_sample);
					errors++;
				end
				if (run_last !== e.run_last) begin
					$display("%0t: run_last expected %b actual %b", $realtime, e.run_last, run_last);
					errors++;
				end
				if (sound_done !== e.sound_done) begin
					$display("%0t: sound_done expected %b actual %b", $realtime, e.sound_done,
						sound_done);
					errors++;
				end
			end
		end
	end

	// Receiver: stall in patterns of varying density, with one long hold-off on request
	initial begin
		int mode;
		out_stall = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			repeat ($urandom_range(10, 60)) begin
				@(posedge clk);
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= 1'($urandom_range(0, 1));
					default: out_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
			if (hold_req) begin
				hold_req = 1'b0;
				@(posedge clk);
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
			end
		end
	end

	initial begin
		stim_row_t rows [$];
		stim_row_t r;
		int n, len;
		logic lst;

		errors = 0;
		burst_left = 0;
		hold_req = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_sample = '0;
		in_last = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_STEP;
		cfg_data = '0;
		r_step = 65536;
		r_in16 = 1;
		r_out8 = 0;
		r_half = 0;
		r_count = 1;
		clear_sound();

		// Directed table: typed results where they are obvious, predictor elsewhere
		rows = '{
			'{ROW_WORD, CFG_STEP, 24'h7FFF, 1'b0, 1, 16'h7FFF},
			'{ROW_WORD, CFG_STEP, 24'h8000, 1'b0, 0, 16'h0},
			'{ROW_WORD, CFG_STEP, 24'h1234, 1'b1, 0, 16'h0},
			'{ROW_WORD, CFG_STEP, 24'h8000, 1'b1, 1, 16'h8000},
			'{ROW_WORD, CFG_STEP, 24'h0001, 1'b1, 1, 16'h0001},
			'{ROW_CFG, CFG_IN_16BIT, 24'd0, 1'b0, 0, 16'h0},
			'{ROW_WORD, CFG_STEP, 24'h00FF, 1'b1, 1, 16'h7F00},
			'{ROW_WORD, CFG_STEP, 24'hFF00, 1'b1, 1, 16'h8000},
			'{ROW_CFG, CFG_OUT_8BIT, 24'd1, 1'b0, 0, 16'h0},
			'{ROW_WORD, CFG_STEP, 24'h0080, 1'b1, 1, 16'h0000},
			'{ROW_WORD, CFG_STEP, 24'h00FF, 1'b1, 1, 16'h007F},
			'{ROW_CFG, CFG_IN_16BIT, 24'd1, 1'b0, 0, 16'h0},
			'{ROW_CFG, CFG_STEP, 24'd0, 1'b0, 0, 16'h0},
			'{ROW_CFG, CFG_BOX_HALF, 24'd7, 1'b0, 0, 16'h0},
			'{ROW_CFG, CFG_OUT_COUNT, 24'd10, 1'b0, 0, 16'h0},
			'{ROW_WORD, CFG_STEP, 24'h7FFF, 1'b0, -1, 16'h0},
			'{ROW_WORD, CFG_STEP, 24'h8000, 1'b0, -1, 16'h0},
			'{ROW_WORD, CFG_STEP, 24'h1000, 1'b1, -1, 16'h0},
			'{ROW_CFG, CFG_OUT_8BIT, 24'd0, 1'b0, 0, 16'h0},
			'{ROW_CFG, CFG_STEP, 24'hFFFFFF, 1'b0, 0, 16'h0},
			'{ROW_CFG, CFG_OUT_COUNT, 24'hFFFFFF, 1'b0, 0, 16'h0},
			'{ROW_CFG, CFG_BOX_HALF, 24'd0, 1'b0, 0, 16'h0},
			'{ROW_WORD, CFG_STEP, 24'h8000, 1'b0, -1, 16'h0},
			'{ROW_WORD, CFG_STEP, 24'h7FFF, 1'b0, -1, 16'h0},
			'{ROW_WORD, CFG_STEP, 24'h0000, 1'b1, -1, 16'h0},
			'{ROW_CFG, CFG_STEP, 24'd98304, 1'b0, 0, 16'h0},
			'{ROW_CFG, CFG_OUT_COUNT, 24'd3, 1'b0, 0, 16'h0},
			'{ROW_WORD, CFG_STEP, 24'h1111, 1'b0, -1, 16'h0},
			'{ROW_WORD, CFG_STEP, 24'h2222, 1'b0, -1, 16'h0},
			'{ROW_WORD, CFG_STEP, 24'hC333, 1'b0, -1, 16'h0},
			'{ROW_WORD, CFG_STEP, 24'h4444, 1'b0, -1, 16'h0},
			'{ROW_WORD, CFG_STEP, 24'h5555, 1'b0, -1, 16'h0},
			'{ROW_WORD, CFG_STEP, 24'hA666, 1'b1, -1, 16'h0},
			'{ROW_CFG, CFG_OUT_COUNT, 24'd0, 1'b0, 0, 16'h0},
			'{ROW_WORD, CFG_STEP, 24'h5555, 1'b1, -1, 16'h0}
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			r = rows[i];
			if (r.kind == ROW_CFG) begin
				drain();
				write_reg(r.idx, r.data);
			end else begin
				send_word(r.data[15:0], r.last, r.n_typed, '0);
				if (r.n_typed > 0) expected_q[$].smp = r.typed_smp;
			end
		end

		// Random phases: well-formed sounds with random content, a little noise
		for (int ph = 0; ph < 12; ph++) begin
			drain();
			case (ph)
				0: write_reg(CFG_STEP, 24'd4096);
				1: write_reg(CFG_STEP, 24'hFFFFFF);
				2: write_reg(CFG_STEP, 24'd65535);
				default:
					case ($urandom_range(0, 5))
						0: write_reg(CFG_STEP, 24'($urandom_range(0, 4095)));
						1: write_reg(CFG_STEP, 24'd65536);
						2: write_reg(CFG_STEP, 24'($urandom_range(65536, 300000)));
						3: write_reg(CFG_STEP, 24'($urandom_range(0, 24'hFFFFFF)));
						default: write_reg(CFG_STEP, 24'($urandom_range(4096, 65535)));
					endcase
			endcase
			write_reg(CFG_IN_16BIT, 24'($urandom_range(0, 1)));
			write_reg(CFG_OUT_8BIT, 24'($urandom_range(0, 1)));
			write_reg(CFG_BOX_HALF, (ph == 0) ? 24'd4 : 24'($urandom_range(0, 7)));
			case ($urandom_range(0, 7))
				0: write_reg(CFG_OUT_COUNT, 24'hFFFFFF);
				1: write_reg(CFG_OUT_COUNT, 24'($urandom_range(0, 1)));
				default: write_reg(CFG_OUT_COUNT, 24'($urandom_range(2, 40)));
			endcase
			// Long receiver hold-off while the sender keeps offering words
			if (ph == 3) hold_req = 1'b1;
			n = 0;
			while (n < 25) begin
				len = $urandom_range(1, 10);
				for (int j = 0; j < len; j++) begin
					lst = (j == len - 1);
					if ($urandom_range(0, 19) == 0) lst = ~lst;
					send_word(16'($urandom), lst, -1, '0);
					n++;
				end
			end
			// Make sure the phase ends on a sound boundary
			send_word(16'($urandom), 1'b1, -1, '0);
		end

		drain();
		repeat (40) @(posedge clk);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
